FILE: hdl/bto_pkg.sv
// Shared types and constants for the binomial tree option pricer.
// Holds the beat payload structs, register indexes, sequencer states and cell controls.
// No dependencies; every other file of the block imports this package.
package bto_pkg;

    // Fixed-point one in Q1.31, used for probability and discount clamping.
    localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

    // Width of the configuration register index.
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_UP_FACTOR       = 3'd0,
        REG_DOWN_FACTOR     = 3'd1,
        REG_UP_PROBABILITY  = 3'd2,
        REG_DISCOUNT_FACTOR = 3'd3,
        REG_AMERICAN_MODE   = 3'd4,
        REG_STEP_COUNT      = 3'd5
    } cfg_reg_t;

    // Input beat: spot in Q16.16 and integer strike.
    typedef struct packed {
        logic [31:0] spot_price;
        logic [15:0] strike;
    } in_item_t;

    // Output beat: root call and put values in Q16.16.
    typedef struct packed {
        logic [31:0] call_price;
        logic [31:0] put_price;
    } out_item_t;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_LEAF,
        ST_MIX_A,
        ST_MIX_B,
        ST_MIX_C,
        ST_DONE
    } seq_state_t;

    // Operation broadcast to every cell of the row.
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_SETUP,
        OP_LEAF,
        OP_MIX_A,
        OP_MIX_B,
        OP_MIX_C
    } cell_op_t;

    // Control and operand group shared by all cells.
    typedef struct packed {
        cell_op_t    op;
        logic [31:0] up;
        logic [31:0] down;
        logic [31:0] prob;
        logic [31:0] prob_c;
        logic [31:0] disc;
        logic [31:0] strike_q;
        logic        american;
    } cell_ctrl_t;

endpackage

FILE: hdl/binomial_tree_option_pricer_top.sv
// Binomial tree option pricer: an accepted item with step count n runs a setup pass
// over columns 0 to n, a leaf pass, one MIX_A, MIX_B, MIX_C sequence per tree level
// and an output load, and the next item is taken once the row is idle again. Each
// level is split into these three states by each cell's multiply-add-multiply recurrence,
// which must close before the level below can start. The row holds MAX_STEPS+1 cells,
// each with a local memory of MAX_STEPS+1 prices for its tree column. No clearing
// pass is needed after reset. Depends on bto_pkg and bto_cell.
module binomial_tree_option_pricer_top #(
    parameter int MAX_STEPS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  bto_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output bto_pkg::out_item_t                out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bto_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                       cfg_data
);
    import bto_pkg::*;

    localparam int AW = $clog2(MAX_STEPS + 1);
    localparam int CELLS = MAX_STEPS + 1;

    logic [31:0] up_reg;
    logic [31:0] down_reg;
    logic [31:0] prob_reg;
    logic [31:0] disc_reg;
    logic        american_reg;
    logic [6:0]  steps_reg;

    seq_state_t  state_reg, state_next;
    logic [AW-1:0] step_reg, step_next;
    logic [31:0] spot_reg;
    logic [15:0] strike_reg;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_reg;

    logic [AW-1:0] n_eff;
    logic        in_take;
    logic        out_take;
    logic        out_load;
    cell_ctrl_t  ctrl;
    logic [31:0] prob_eff;
    logic [31:0] disc_eff;

    logic [31:0] price_bus [CELLS];
    logic [31:0] call_bus [CELLS];
    logic [31:0] put_bus [CELLS];

    // Configuration writes.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg       <= 32'h4000_0000;
            down_reg     <= 32'h4000_0000;
            prob_reg     <= 32'h4000_0000;
            disc_reg     <= ONE_Q31;
            american_reg <= 1'b0;
            steps_reg    <= 7'd64;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_UP_FACTOR:       up_reg       <= cfg_data;
                REG_DOWN_FACTOR:     down_reg     <= cfg_data;
                REG_UP_PROBABILITY:  prob_reg     <= cfg_data;
                REG_DISCOUNT_FACTOR: disc_reg     <= cfg_data;
                REG_AMERICAN_MODE:   american_reg <= cfg_data[0];
                REG_STEP_COUNT:      steps_reg    <= cfg_data[6:0];
                default:
                begin
                end
            endcase
        end
    end

    // Effective step count and clamped probability and discount.
    always_comb
    begin
        if (steps_reg == 7'd0)
        begin
            n_eff = AW'(1);
        end
        else if (32'(steps_reg) > 32'(MAX_STEPS))
        begin
            n_eff = AW'(MAX_STEPS);
        end
        else
        begin
            n_eff = AW'(steps_reg);
        end
        prob_eff = (prob_reg > ONE_Q31) ? ONE_Q31 : prob_reg;
        disc_eff = (disc_reg > ONE_Q31) ? ONE_Q31 : disc_reg;
    end

    // Sequencer state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input capture and result load.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            spot_reg   <= in_data.spot_price;
            strike_reg <= in_data.strike;
        end
        if (out_load)
        begin
            out_reg.call_price <= call_bus[0];
            out_reg.put_price  <= put_bus[0];
        end
    end

    // Next state and cell operation.
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        in_take        = 1'b0;
        out_load       = 1'b0;
        out_take       = out_valid_reg && !out_stall;
        in_stall       = 1'b1;
        ctrl.op        = OP_HOLD;
        ctrl.up        = up_reg;
        ctrl.down      = down_reg;
        ctrl.prob      = prob_eff;
        ctrl.prob_c    = ONE_Q31 - prob_eff;
        ctrl.disc      = disc_eff;
        ctrl.strike_q  = {strike_reg, 16'h0000};
        ctrl.american  = american_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    in_take    = 1'b1;
                    step_next  = '0;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                ctrl.op = OP_SETUP;
                if (step_reg == n_eff)
                begin
                    state_next = ST_LEAF;
                end
                else
                begin
                    step_next = step_reg + AW'(1);
                end
            end
            ST_LEAF:
            begin
                ctrl.op    = OP_LEAF;
                step_next  = n_eff - AW'(1);
                state_next = ST_MIX_A;
            end
            ST_MIX_A:
            begin
                ctrl.op    = OP_MIX_A;
                state_next = ST_MIX_B;
            end
            ST_MIX_B:
            begin
                ctrl.op    = OP_MIX_B;
                state_next = ST_MIX_C;
            end
            ST_MIX_C:
            begin
                ctrl.op = OP_MIX_C;
                if (step_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next  = step_reg - AW'(1);
                    state_next = ST_MIX_A;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_take)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = out_load ? 1'b1 : (out_take ? 1'b0 : out_valid_reg);
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Row of cells, one per tree column.
    for (genvar j = 0; j < CELLS; j++)
    begin : g_cell
        logic [31:0] left_p;
        logic [31:0] right_c;
        logic [31:0] right_p;
        if (j == 0)
        begin : g_first
            assign left_p = spot_reg;
        end
        else
        begin : g_link
            assign left_p = price_bus[j-1];
        end
        if (j == CELLS - 1)
        begin : g_last
            assign right_c = 32'd0;
            assign right_p = 32'd0;
        end
        else
        begin : g_mid
            assign right_c = call_bus[j+1];
            assign right_p = put_bus[j+1];
        end
        bto_cell #(
            .MAX_STEPS (MAX_STEPS),
            .J         (j)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .step       (step_reg),
            .left_price (left_p),
            .right_call (right_c),
            .right_put  (right_p),
            .price      (price_bus[j]),
            .call_val   (call_bus[j]),
            .put_val    (put_bus[j])
        );
    end

`ifndef SYNTHESIS
    // The setup count never runs past the tree depth.
    a_setup_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg == ST_SETUP && step_reg > n_eff))
        else $error("setup count beyond step count");

    // An accepted beat starts setup at column zero.
    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_SETUP && step_reg == '0))
        else $error("accepted beat did not start setup");

    // Levels above the root loop back to the next level.
    a_level_loop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MIX_C && step_reg != '0) |=> (state_reg == ST_MIX_A))
        else $error("level loop broken");

    // A result appears only after the root level finished.
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside completion");
`endif

endmodule

FILE: hdl/bto_cell.sv
// One cell of the pricing row: owns tree column J, its node prices and option values.
// Builds its price column during setup, then runs one backward-induction level per pass.
// Depends on bto_pkg.
module bto_cell #(
    parameter int MAX_STEPS = 64,
    parameter int J = 0
) (
    input  logic                             clk,
    input  bto_pkg::cell_ctrl_t              ctrl,
    input  logic [$clog2(MAX_STEPS+1)-1:0]   step,
    input  logic [31:0]                      left_price,
    input  logic [31:0]                      right_call,
    input  logic [31:0]                      right_put,
    output logic [31:0]                      price,
    output logic [31:0]                      call_val,
    output logic [31:0]                      put_val
);
    import bto_pkg::*;

    localparam int AW = $clog2(MAX_STEPS + 1);
    localparam int DEPTH = MAX_STEPS + 1;
    localparam logic [AW-1:0] JW = AW'(J);

    logic [31:0] price_reg;
    logic [31:0] call_reg;
    logic [31:0] put_reg;
    logic [63:0] call_up_reg;
    logic [63:0] call_dn_reg;
    logic [63:0] put_up_reg;
    logic [63:0] put_dn_reg;
    logic [63:0] call_disc_reg;
    logic [63:0] put_disc_reg;
    logic [31:0] rd_reg;
    logic [31:0] mem [DEPTH];

    logic        at_start;
    logic        reached;
    logic [AW-1:0] offs;
    logic [31:0] mul_a;
    logic [31:0] mul_f;
    logic [63:0] mul_w;
    logic [31:0] price_next;
    logic [63:0] call_sum;
    logic [63:0] put_sum;
    logic [31:0] call_mix;
    logic [31:0] put_mix;
    logic [31:0] call_ex;
    logic [31:0] put_ex;
    logic [31:0] call_new;
    logic [31:0] put_new;

    // Price chain: the first step takes one up move from the left neighbor (cell 0 takes
    // the left price as is), every later step one down move of the own price, truncated and saturated.
    always_comb
    begin
        at_start = (step == JW);
        reached  = (step >= JW);
        offs     = step - JW;
        mul_a    = at_start ? left_price : price_reg;
        mul_f    = at_start ? ctrl.up : ctrl.down;
        mul_w    = 64'(mul_a) * 64'(mul_f);
        if (J == 0 && at_start)
        begin
            price_next = left_price;
        end
        else if (mul_w[63:62] != 2'b00)
        begin
            price_next = 32'hFFFF_FFFF;
        end
        else
        begin
            price_next = mul_w[61:30];
        end
    end

    // Mix of up and down values, then in American mode early exercise against the stored price.
    always_comb
    begin
        call_sum = call_up_reg + call_dn_reg;
        put_sum  = put_up_reg + put_dn_reg;
        call_mix = call_disc_reg[62:31];
        put_mix  = put_disc_reg[62:31];
        call_ex  = (rd_reg > ctrl.strike_q) ? rd_reg - ctrl.strike_q : 32'd0;
        put_ex   = (ctrl.strike_q > rd_reg) ? ctrl.strike_q - rd_reg : 32'd0;
        call_new = (ctrl.american && call_ex > call_mix) ? call_ex : call_mix;
        put_new  = (ctrl.american && put_ex > put_mix) ? put_ex : put_mix;
    end

    // Datapath registers of the cell.
    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            OP_SETUP:
            begin
                if (reached)
                begin
                    price_reg <= price_next;
                end
            end
            OP_LEAF:
            begin
                call_reg <= (price_reg > ctrl.strike_q) ? price_reg - ctrl.strike_q : 32'd0;
                put_reg  <= (ctrl.strike_q > price_reg) ? ctrl.strike_q - price_reg : 32'd0;
            end
            OP_MIX_A:
            begin
                if (reached)
                begin
                    call_up_reg <= 64'(ctrl.prob) * 64'(right_call);
                    call_dn_reg <= 64'(ctrl.prob_c) * 64'(call_reg);
                    put_up_reg  <= 64'(ctrl.prob) * 64'(right_put);
                    put_dn_reg  <= 64'(ctrl.prob_c) * 64'(put_reg);
                end
            end
            OP_MIX_B:
            begin
                if (reached)
                begin
                    call_disc_reg <= 64'(ctrl.disc) * 64'(call_sum[62:31]);
                    put_disc_reg  <= 64'(ctrl.disc) * 64'(put_sum[62:31]);
                end
            end
            OP_MIX_C:
            begin
                if (reached)
                begin
                    call_reg <= call_new;
                    put_reg  <= put_new;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Column price memory: written during setup, read once per level.
    always_ff @(posedge clk)
    begin
        if (ctrl.op == OP_SETUP && reached)
        begin
            mem[offs] <= price_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.op == OP_MIX_A && reached)
        begin
            rd_reg <= mem[offs];
        end
    end

    assign price    = price_reg;
    assign call_val = call_reg;
    assign put_val  = put_reg;

endmodule
